### src/assert_macros.svh
// Assertion helpers shared by the RTL. Each use samples on aclk and is
// switched off while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define TSP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`define TSP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/tsp_pkg.sv
package tsp_pkg;

    localparam int POINTS_PER_DAY = 7;
    localparam int NUM_TABLES     = 3;
    localparam int NUM_DAYS       = 7;
    localparam int NUM_ENTRIES    = NUM_TABLES * NUM_DAYS * POINTS_PER_DAY;
    localparam int DAY_STRIDE     = POINTS_PER_DAY;
    localparam int TABLE_STRIDE   = NUM_DAYS * POINTS_PER_DAY;
    localparam int ADDR_W         = $clog2(NUM_ENTRIES);
    localparam int IDX_W          = (POINTS_PER_DAY > 1) ? $clog2(POINTS_PER_DAY) : 1;
    localparam int TIME_W         = 17;
    localparam int TEMP_W         = 11;
    localparam int PROG_W         = 3;
    localparam int TBL_W          = 2;
    localparam int FUNC_W         = 3;
    localparam int SEC_PER_HOUR   = 3600;
    localparam int SEC_PER_MIN    = 60;

    localparam logic [FUNC_W-1:0] FUNC_SELECT   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_SET_OVR  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLR_OVR  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_QUERY    = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_PROG_ID  = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_READ_DAY = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_WR_TEMP  = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_WR_TIME  = 3'd7;

    localparam logic [PROG_W-1:0] PROG_OFF   = 3'd0;
    localparam logic [PROG_W-1:0] PROG_ON    = 3'd1;
    localparam logic [PROG_W-1:0] PROG_SCHED = 3'd2;
    localparam logic [PROG_W-1:0] PROG_AWAY  = 3'd3;
    localparam logic [PROG_W-1:0] PROG_OVR   = 3'd4;

    localparam logic [TBL_W-1:0] TBL_AWAY = 2'd2;

    localparam logic [TEMP_W-1:0] TEMP_OFF  = 11'd80;
    localparam logic [TEMP_W-1:0] TEMP_ON   = 11'd800;
    localparam logic [TEMP_W-1:0] TEMP_AWAY = 11'd240;

    typedef logic [TIME_W-1:0] time_list_t [7];
    typedef logic [TEMP_W-1:0] temp_list_t [7];

    localparam time_list_t DFLT_SCHED_TIME =
        '{17'd0, 17'd10800, 17'd21600, 17'd30600, 17'd61200, 17'd66600, 17'd85500};
    localparam temp_list_t DFLT_SCHED_TEMP =
        '{11'd320, 11'd336, 11'd352, 11'd272, 11'd336, 11'd360, 11'd320};
    localparam time_list_t DFLT_AWAY_TIME =
        '{17'd0, 17'd18000, 17'd30600, 17'd61200, 17'd64800, 17'd84600, 17'd84600};

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
    } rd_req_t;

    typedef struct packed {
        logic              we_time;
        logic              we_temp;
        logic [ADDR_W-1:0] addr;
        logic [TIME_W-1:0] start;
        logic [TEMP_W-1:0] temp;
    } wr_req_t;

    typedef struct packed {
        logic [TIME_W-1:0] start;
        logic [TEMP_W-1:0] temp;
    } entry_t;

    function automatic logic [2:0] dflt_slot(input logic [IDX_W-1:0] idx);
        logic [2:0] k;
        if (32'(idx) < 7) begin
            k = 3'(idx);
        end else begin
            k = 3'd6;
        end
        return k;
    endfunction

    function automatic logic [TIME_W-1:0] dflt_time(input logic [TBL_W-1:0] tbl,
                                                   input logic [IDX_W-1:0] idx);
        logic [2:0] k;
        k = dflt_slot(idx);
        return (tbl == TBL_AWAY) ? DFLT_AWAY_TIME[k] : DFLT_SCHED_TIME[k];
    endfunction

    function automatic logic [TEMP_W-1:0] dflt_temp(input logic [TBL_W-1:0] tbl,
                                                   input logic [IDX_W-1:0] idx);
        logic [2:0] k;
        k = dflt_slot(idx);
        return (tbl == TBL_AWAY) ? TEMP_AWAY : DFLT_SCHED_TEMP[k];
    endfunction

endpackage

### src/tsp_ram.sv
module tsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      aclk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/tsp_store.sv
module tsp_store
    import tsp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  rd_req_t rd_req,
    input  wr_req_t wr_req,
    output logic    init_done,
    output entry_t  rd_entry
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POINTS_PER_DAY - 1);
    localparam logic [2:0]       LAST_DAY = 3'(NUM_DAYS - 1);
    localparam logic [TBL_W-1:0] LAST_TBL = TBL_W'(NUM_TABLES - 1);

    // After reset the default points are loaded, one point a cycle.
    logic               init_done_reg;
    logic [TBL_W-1:0]   init_tbl_reg;
    logic [2:0]         init_day_reg;
    logic [IDX_W-1:0]   init_idx_reg;
    logic [ADDR_W-1:0]  init_addr_reg;
    logic               we_time;
    logic               we_temp;
    logic [ADDR_W-1:0]  waddr;
    logic [TIME_W-1:0]  wtime;
    logic [TEMP_W-1:0]  wtemp;
    logic [TIME_W-1:0]  ram_time;
    logic [TEMP_W-1:0]  ram_temp;

    assign we_time = !init_done_reg || wr_req.we_time;
    assign we_temp = !init_done_reg || wr_req.we_temp;
    assign waddr   = init_done_reg ? wr_req.addr : init_addr_reg;
    assign wtime   = init_done_reg ? wr_req.start : dflt_time(init_tbl_reg, init_idx_reg);
    assign wtemp   = init_done_reg ? wr_req.temp : dflt_temp(init_tbl_reg, init_idx_reg);

    tsp_ram #(.WIDTH(TIME_W), .DEPTH(NUM_ENTRIES)) u_time_ram (
        .aclk  (aclk),
        .we    (we_time),
        .waddr (waddr),
        .wdata (wtime),
        .raddr (rd_req.addr),
        .rdata (ram_time)
    );

    tsp_ram #(.WIDTH(TEMP_W), .DEPTH(NUM_ENTRIES)) u_temp_ram (
        .aclk  (aclk),
        .we    (we_temp),
        .waddr (waddr),
        .wdata (wtemp),
        .raddr (rd_req.addr),
        .rdata (ram_temp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_done_reg <= 1'b0;
            init_tbl_reg  <= '0;
            init_day_reg  <= '0;
            init_idx_reg  <= '0;
            init_addr_reg <= '0;
        end else if (!init_done_reg) begin
            init_addr_reg <= init_addr_reg + ADDR_W'(1);
            if (init_idx_reg == LAST_IDX) begin
                init_idx_reg <= '0;
                if (init_day_reg == LAST_DAY) begin
                    init_day_reg <= '0;
                    if (init_tbl_reg == LAST_TBL) begin
                        init_done_reg <= 1'b1;
                    end else begin
                        init_tbl_reg <= init_tbl_reg + TBL_W'(1);
                    end
                end else begin
                    init_day_reg <= init_day_reg + 3'd1;
                end
            end else begin
                init_idx_reg <= init_idx_reg + IDX_W'(1);
            end
        end
    end

    assign init_done      = init_done_reg;
    assign rd_entry.start = ram_time;
    assign rd_entry.temp  = ram_temp;

endmodule

### src/thermostat_schedule_programmer.sv
// Two-zone heating programmer with zone 1, zone 2 and away weekly tables.
// Input words arrive on s_valid/s_ready and carry a function code with its
// operands; result words leave on m_valid/m_ready, m_last marking the final
// word of each input word. Select, override, clear and table writes give
// no word. A program id query, or a setpoint query on the off, on or
// override program, gives one word through ST_DELIVER into the output register.
// A setpoint query on the schedule or away program walks the day's points
// through the shared table read port and comparator, one point a cycle.
// A day read gives POINTS_PER_DAY words, each read in ST_RD_PRIME and
// presented from ST_RD_OUT, as the table read is registered. s_ready is
// high only in idle, so no input word is taken before the last one is done.
// A result word is held in the output register while m_ready is low; the
// next input word is still accepted, but any further result waits for it.
// After reset both zones run the off program and no override is saved. The
// tables are then loaded with their default points, one point a cycle, so
// s_ready stays low until all NUM_ENTRIES (147) points are loaded.
module thermostat_schedule_programmer
    import tsp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [FUNC_W-1:0] s_func,
    input  logic              s_zone,
    input  logic [2:0]        s_program_select,
    input  logic [TBL_W-1:0]  s_table_select,
    input  logic [2:0]        s_day,
    input  logic [2:0]        s_entry_index,
    input  logic [TEMP_W-1:0] s_temperature,
    input  logic [TIME_W-1:0] s_start_time,
    input  logic [2:0]        s_weekday,
    input  logic [4:0]        s_hour,
    input  logic [5:0]        s_minute,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [TEMP_W-1:0] m_setpoint_temp,
    output logic [PROG_W-1:0] m_program_id,
    output logic [TIME_W-1:0] m_entry_time,
    output logic [TEMP_W-1:0] m_entry_temp,
    output logic              m_last
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK_PRIME,
        ST_WALK,
        ST_RD_PRIME,
        ST_RD_OUT,
        ST_DELIVER
    } state_t;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POINTS_PER_DAY - 1);

    state_t             state_reg, state_next;
    logic [PROG_W-1:0]  active_reg [2];
    logic [PROG_W-1:0]  active_next [2];
    logic [PROG_W-1:0]  saved_reg [2];
    logic [PROG_W-1:0]  saved_next [2];
    logic               saved_valid_reg [2];
    logic               saved_valid_next [2];
    logic [TEMP_W-1:0]  ovr_temp_reg [2];
    logic [TEMP_W-1:0]  ovr_temp_next [2];
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [ADDR_W-1:0]  last_addr_reg, last_addr_next;
    logic [IDX_W-1:0]   ridx_reg, ridx_next;
    logic [IDX_W-1:0]   chk_reg, chk_next;
    logic [TIME_W-1:0]  now_reg, now_next;
    logic [TEMP_W-1:0]  sel_reg, sel_next;
    logic [TEMP_W-1:0]  res_sp_reg, res_sp_next;
    logic [PROG_W-1:0]  res_prog_reg, res_prog_next;
    logic               m_valid_reg, m_valid_next;
    logic [TEMP_W-1:0]  m_sp_reg, m_sp_next;
    logic [PROG_W-1:0]  m_prog_reg, m_prog_next;
    logic [TIME_W-1:0]  m_time_reg, m_time_next;
    logic [TEMP_W-1:0]  m_temp_reg, m_temp_next;
    logic               m_last_reg, m_last_next;

    rd_req_t            rd_req;
    wr_req_t            wr_req;
    entry_t             rd_entry;

    logic               init_done;
    logic               accept;
    logic               out_free;
    logic               tbl_ok;
    logic               idx_ok;
    logic [2:0]         today;
    logic [TBL_W-1:0]   walk_tbl;
    logic [ADDR_W-1:0]  walk_base;
    logic [ADDR_W-1:0]  day_base;
    logic [TIME_W-1:0]  now_calc;

    tsp_store u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_req    (rd_req),
        .wr_req    (wr_req),
        .init_done (init_done),
        .rd_entry  (rd_entry)
    );

    assign s_ready  = (state_reg == ST_IDLE) && init_done;
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign tbl_ok   = (32'(s_table_select) < NUM_TABLES) && (s_day != 3'd0);
    assign idx_ok   = 32'(s_entry_index) < POINTS_PER_DAY;
    assign today    = (s_weekday >= 3'd2) ? (s_weekday - 3'd2) : 3'd6;
    assign walk_tbl = (active_reg[s_zone] == PROG_SCHED) ? {1'b0, s_zone} : TBL_AWAY;
    assign now_calc = TIME_W'(s_hour) * TIME_W'(SEC_PER_HOUR)
                    + TIME_W'(s_minute) * TIME_W'(SEC_PER_MIN);

    assign walk_base = ADDR_W'(walk_tbl) * ADDR_W'(TABLE_STRIDE)
                     + ADDR_W'(today) * ADDR_W'(DAY_STRIDE);
    assign day_base  = ADDR_W'(s_table_select) * ADDR_W'(TABLE_STRIDE)
                     + ADDR_W'(s_day - 3'd1) * ADDR_W'(DAY_STRIDE);

    assign rd_req.addr = addr_reg;

    always_comb begin
        state_next       = state_reg;
        active_next      = active_reg;
        saved_next       = saved_reg;
        saved_valid_next = saved_valid_reg;
        ovr_temp_next    = ovr_temp_reg;
        addr_next        = addr_reg;
        last_addr_next   = last_addr_reg;
        ridx_next        = ridx_reg;
        chk_next         = chk_reg;
        now_next         = now_reg;
        sel_next         = sel_reg;
        res_sp_next      = res_sp_reg;
        res_prog_next    = res_prog_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_sp_next        = m_sp_reg;
        m_prog_next      = m_prog_reg;
        m_time_next      = m_time_reg;
        m_temp_next      = m_temp_reg;
        m_last_next      = m_last_reg;

        wr_req.we_time = 1'b0;
        wr_req.we_temp = 1'b0;
        wr_req.addr    = day_base + ADDR_W'(s_entry_index);
        wr_req.start   = s_start_time;
        wr_req.temp    = s_temperature;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_func)
                        FUNC_SELECT: begin
                            if (s_program_select <= PROG_OVR) begin
                                active_next[s_zone] = s_program_select;
                            end
                        end
                        FUNC_SET_OVR: begin
                            if (!saved_valid_reg[s_zone]) begin
                                saved_next[s_zone]       = active_reg[s_zone];
                                saved_valid_next[s_zone] = 1'b1;
                                active_next[s_zone]      = PROG_OVR;
                            end
                            ovr_temp_next[s_zone] = s_temperature;
                        end
                        FUNC_CLR_OVR: begin
                            if (saved_valid_reg[s_zone]) begin
                                active_next[s_zone]      = saved_reg[s_zone];
                                saved_valid_next[s_zone] = 1'b0;
                                saved_next[s_zone]       = PROG_OFF;
                            end
                        end
                        FUNC_QUERY: begin
                            res_prog_next = PROG_OFF;
                            state_next    = ST_DELIVER;
                            case (active_reg[s_zone]) inside
                                PROG_OFF: res_sp_next = TEMP_OFF;
                                PROG_ON:  res_sp_next = TEMP_ON;
                                PROG_SCHED, PROG_AWAY: begin
                                    addr_next      = walk_base;
                                    last_addr_next = walk_base
                                                   + ADDR_W'(POINTS_PER_DAY - 1);
                                    now_next       = now_calc;
                                    sel_next       = '0;
                                    state_next     = ST_WALK_PRIME;
                                end
                                default:  res_sp_next = ovr_temp_reg[s_zone];
                            endcase
                        end
                        FUNC_PROG_ID: begin
                            res_sp_next   = '0;
                            res_prog_next = active_reg[s_zone];
                            state_next    = ST_DELIVER;
                        end
                        FUNC_READ_DAY: begin
                            if (tbl_ok) begin
                                addr_next  = day_base;
                                ridx_next  = '0;
                                state_next = ST_RD_PRIME;
                            end
                        end
                        FUNC_WR_TEMP: begin
                            wr_req.we_temp = tbl_ok && idx_ok;
                        end
                        FUNC_WR_TIME: begin
                            wr_req.we_time = tbl_ok && idx_ok;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_WALK_PRIME: begin
                chk_next   = '0;
                state_next = ST_WALK;
                if (addr_reg != last_addr_reg) begin
                    addr_next = addr_reg + ADDR_W'(1);
                end
            end
            ST_WALK: begin
                // The read address runs one point ahead of the compared point.
                res_prog_next = PROG_OFF;
                if (rd_entry.start > now_reg) begin
                    res_sp_next = sel_reg;
                    state_next  = ST_DELIVER;
                end else if (chk_reg == LAST_IDX) begin
                    res_sp_next = rd_entry.temp;
                    state_next  = ST_DELIVER;
                end else begin
                    sel_next = rd_entry.temp;
                    chk_next = chk_reg + IDX_W'(1);
                    if (addr_reg != last_addr_reg) begin
                        addr_next = addr_reg + ADDR_W'(1);
                    end
                end
            end
            ST_RD_PRIME: begin
                state_next = ST_RD_OUT;
            end
            ST_RD_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_sp_next    = '0;
                    m_prog_next  = PROG_OFF;
                    m_time_next  = rd_entry.start;
                    m_temp_next  = rd_entry.temp;
                    m_last_next  = (ridx_reg == LAST_IDX);
                    if (ridx_reg == LAST_IDX) begin
                        state_next = ST_IDLE;
                    end else begin
                        addr_next  = addr_reg + ADDR_W'(1);
                        ridx_next  = ridx_reg + IDX_W'(1);
                        state_next = ST_RD_PRIME;
                    end
                end
            end
            ST_DELIVER: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_sp_next    = res_sp_reg;
                    m_prog_next  = res_prog_reg;
                    m_time_next  = '0;
                    m_temp_next  = '0;
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            for (int z = 0; z < 2; z++) begin
                active_reg[z]      <= PROG_OFF;
                saved_reg[z]       <= PROG_OFF;
                saved_valid_reg[z] <= 1'b0;
                ovr_temp_reg[z]    <= '0;
            end
        end else begin
            state_reg       <= state_next;
            m_valid_reg     <= m_valid_next;
            active_reg      <= active_next;
            saved_reg       <= saved_next;
            saved_valid_reg <= saved_valid_next;
            ovr_temp_reg    <= ovr_temp_next;
        end
        addr_reg      <= addr_next;
        last_addr_reg <= last_addr_next;
        ridx_reg      <= ridx_next;
        chk_reg       <= chk_next;
        now_reg       <= now_next;
        sel_reg       <= sel_next;
        res_sp_reg    <= res_sp_next;
        res_prog_reg  <= res_prog_next;
        m_sp_reg      <= m_sp_next;
        m_prog_reg    <= m_prog_next;
        m_time_reg    <= m_time_next;
        m_temp_reg    <= m_temp_next;
        m_last_reg    <= m_last_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_setpoint_temp = m_sp_reg;
    assign m_program_id    = m_prog_reg;
    assign m_entry_time    = m_time_reg;
    assign m_entry_temp    = m_temp_reg;
    assign m_last          = m_last_reg;

`include "assert_macros.svh"

    `TSP_ASSERT_IMP(a_write_idle, wr_req.we_time || wr_req.we_temp, state_reg == ST_IDLE, "table written outside idle")
    `TSP_ASSERT_IMP(a_walk_bound, state_reg == ST_WALK, addr_reg <= last_addr_reg, "walk read beyond the day")
    `TSP_ASSERT_NXT(a_query_busy, accept && s_func == FUNC_QUERY, !s_ready, "query did not occupy the sequencer")
    `TSP_ASSERT_NXT(a_ovr_saved, accept && s_func == FUNC_SET_OVR && !s_zone, saved_valid_reg[0] && active_reg[0] == PROG_OVR || saved_valid_reg[0], "override left no saved program")

endmodule
